// File: design/dfcs_pkg.sv
`timescale 1ns / 1ps

package dfcs_pkg;

    // request kinds carried on the op field
    typedef enum logic [2:0] {
        OP_POLL        = 3'd0,
        OP_CHIP_ERASE  = 3'd1,
        OP_PAGE_ERASE  = 3'd2,
        OP_READ_FLASH  = 3'd3,
        OP_READ_BUFFER = 3'd4,
        OP_LOAD_PAGE   = 3'd5,
        OP_WRITE_BUFFER = 3'd6,
        OP_SAVE_BUFFER = 3'd7
    } op_t;

    // result status codes; codes 5..7 are never produced
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PROC     = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // pending action held between items
    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_ERASE = 2'd1,
        ACT_WAIT  = 2'd2
    } act_t;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    // dataflash opcodes
    localparam logic [7:0] OPC_CHIP_ERASE  = 8'hC7;
    localparam logic [7:0] OPC_CE_BYTE1    = 8'h94;
    localparam logic [7:0] OPC_CE_BYTE2    = 8'h80;
    localparam logic [7:0] OPC_CE_BYTE3    = 8'h9A;
    localparam logic [7:0] OPC_PAGE_ERASE  = 8'h81;
    localparam logic [7:0] OPC_BLOCK_ERASE = 8'h50;
    localparam logic [7:0] OPC_READ_FLASH  = 8'h03;
    localparam logic [7:0] OPC_READ_BUF1   = 8'hD1;
    localparam logic [7:0] OPC_READ_BUF2   = 8'hD3;
    localparam logic [7:0] OPC_LOAD_BUF1   = 8'h53;
    localparam logic [7:0] OPC_LOAD_BUF2   = 8'h55;
    localparam logic [7:0] OPC_WRITE_BUF1  = 8'h84;
    localparam logic [7:0] OPC_WRITE_BUF2  = 8'h87;
    localparam logic [7:0] OPC_SAVE_BUF1   = 8'h83;
    localparam logic [7:0] OPC_SAVE_BUF2   = 8'h86;

    // register indexes on the configuration port
    localparam logic REG_CHIP_ID    = 1'b0;
    localparam logic REG_ERASE_MODE = 1'b1;

    typedef struct packed {
        logic [3:0] expected_chip_id;
        logic       use_real_chip_erase;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] status_byte;
        logic [13:0] page;
        logic [9:0] offset;
        logic [9:0] length;
        logic       buffer_sel;
    } item_t;

    typedef struct packed {
        logic       busy_res;
        logic [2:0] status;
        logic [1:0] data_dir;
        logic [9:0] data_length;
        logic [7:0] addr_lo;
        logic [7:0] addr_mid;
        logic [7:0] addr_hi;
        logic [7:0] opcode;
        logic       cmd_valid;
    } result_t;

endpackage

// File: design/dfcs_core.sv
`timescale 1ns / 1ps

module dfcs_core #(
    parameter int PAGES     = 4096,
    parameter int PAGE_SIZE = 264
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  dfcs_pkg::cfg_t   cfg,
    input  dfcs_pkg::item_t  item,
    output dfcs_pkg::result_t res
);
    import dfcs_pkg::*;

    localparam int BLOCKS = PAGES / 8;
    localparam int BW     = $clog2(BLOCKS + 1);

    act_t          act_reg, act_next;
    logic [BW-1:0] block_reg, block_next;
    logic          issued_reg, issued_next;

    logic            ready;
    logic            id_ok;
    logic [BW-1:0]   block_inc;
    logic [15:0]     block_wide;
    logic [15:0]     page_addr;
    logic [10:0]     span;
    logic            span_bad;
    logic            page_bad;
    result_t         r;

    assign ready      = item.status_byte[7];
    assign id_ok      = item.status_byte[5:2] == cfg.expected_chip_id;
    assign page_addr  = {item.page, 2'b00};
    assign span       = {1'b0, item.offset} + {1'b0, item.length};
    assign span_bad   = span > 11'(PAGE_SIZE);
    assign page_bad   = {1'b0, item.page} >= 15'(PAGES);
    assign block_inc  = block_reg + BW'(1);

    always_comb begin
        r           = '0;
        act_next    = act_reg;
        block_next  = block_reg;
        issued_next = issued_reg;
        block_wide  = '0;

        if (item.op == OP_POLL) begin
            r.status = ST_OK;
            if (act_reg == ACT_ERASE && !cfg.use_real_chip_erase) begin
                r.status = ST_PROC;
                if (!issued_reg) begin
                    block_wide  = 16'({block_reg, 5'b0});
                    r.cmd_valid = 1'b1;
                    r.opcode    = OPC_BLOCK_ERASE;
                    r.addr_hi   = block_wide[15:8];
                    r.addr_mid  = block_wide[7:0];
                    issued_next = 1'b1;
                end else if (ready) begin
                    block_next = block_inc;
                    if (block_inc >= BW'(BLOCKS)) begin
                        act_next    = ACT_IDLE;
                        issued_next = 1'b0;
                        r.status    = ST_OK;
                    end else begin
                        // next block erase goes out on the same poll
                        block_wide  = 16'({block_inc, 5'b0});
                        r.cmd_valid = 1'b1;
                        r.opcode    = OPC_BLOCK_ERASE;
                        r.addr_hi   = block_wide[15:8];
                        r.addr_mid  = block_wide[7:0];
                        issued_next = 1'b1;
                    end
                end
            end else if (act_reg != ACT_IDLE) begin
                if (ready) begin
                    act_next = ACT_IDLE;
                end else begin
                    r.status = ST_PROC;
                end
            end
        end else if (!id_ok) begin
            r.status = ST_NOTFOUND;
        end else if (act_reg != ACT_IDLE) begin
            r.status = ST_BUSY;
        end else begin
            unique case (item.op)
                OP_CHIP_ERASE: begin
                    if (cfg.use_real_chip_erase) begin
                        r.cmd_valid = 1'b1;
                        r.opcode    = OPC_CHIP_ERASE;
                        r.addr_hi   = OPC_CE_BYTE1;
                        r.addr_mid  = OPC_CE_BYTE2;
                        r.addr_lo   = OPC_CE_BYTE3;
                    end
                    block_next  = '0;
                    issued_next = 1'b0;
                    act_next    = ACT_ERASE;
                    r.status    = ST_PROC;
                end
                OP_PAGE_ERASE: begin
                    r.cmd_valid = 1'b1;
                    r.opcode    = OPC_PAGE_ERASE;
                    r.addr_hi   = page_addr[15:8];
                    r.addr_mid  = page_addr[7:0];
                    act_next    = ACT_WAIT;
                    r.status    = ST_PROC;
                end
                OP_READ_FLASH: begin
                    if (item.length == '0) begin
                        r.status = ST_OK;
                    end else if (page_bad || span_bad) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.cmd_valid   = 1'b1;
                        r.opcode      = OPC_READ_FLASH;
                        r.addr_hi     = page_addr[15:8];
                        r.addr_mid    = page_addr[7:0] | {6'b0, item.offset[9:8]};
                        r.addr_lo     = item.offset[7:0];
                        r.data_length = item.length;
                        r.data_dir    = DIR_READ;
                        r.status      = ST_OK;
                    end
                end
                OP_READ_BUFFER: begin
                    if (item.length == '0) begin
                        r.status = ST_OK;
                    end else if (span_bad) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.cmd_valid   = 1'b1;
                        r.opcode      = item.buffer_sel ? OPC_READ_BUF2 : OPC_READ_BUF1;
                        r.addr_mid    = {6'b0, item.offset[9:8]};
                        r.addr_lo     = item.offset[7:0];
                        r.data_length = item.length;
                        r.data_dir    = DIR_READ;
                        r.status      = ST_OK;
                    end
                end
                OP_LOAD_PAGE, OP_SAVE_BUFFER: begin
                    if (page_bad) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.cmd_valid = 1'b1;
                        if (item.op == OP_LOAD_PAGE) begin
                            r.opcode = item.buffer_sel ? OPC_LOAD_BUF2 : OPC_LOAD_BUF1;
                        end else begin
                            r.opcode = item.buffer_sel ? OPC_SAVE_BUF2 : OPC_SAVE_BUF1;
                        end
                        r.addr_hi  = page_addr[15:8];
                        r.addr_mid = page_addr[7:0];
                        act_next   = ACT_WAIT;
                        r.status   = ST_PROC;
                    end
                end
                OP_WRITE_BUFFER: begin
                    if (item.length != '0) begin
                        r.cmd_valid   = 1'b1;
                        r.opcode      = item.buffer_sel ? OPC_WRITE_BUF2 : OPC_WRITE_BUF1;
                        r.addr_mid    = {6'b0, item.offset[9:8]};
                        r.addr_lo     = item.offset[7:0];
                        r.data_length = item.length;
                        r.data_dir    = DIR_WRITE;
                    end
                    r.status = ST_OK;
                end
                default: begin
                    r.status = ST_OK;
                end
            endcase
        end
        r.busy_res = act_next != ACT_IDLE;
    end

    assign res = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg    <= ACT_IDLE;
            block_reg  <= '0;
            issued_reg <= 1'b0;
        end else if (fire) begin
            act_reg    <= act_next;
            block_reg  <= block_next;
            issued_reg <= issued_next;
        end
    end

endmodule

// File: design/dataflash_command_sequencer_top.sv
`timescale 1ns / 1ps

// SPI dataflash command sequencer.
// Input stream (s_*): one request or poll per transfer, with the status byte
// just read from the chip. The request kind travels in s_tuser.
// Result stream (m_*): exactly one transfer per input transfer, holding the
// status code, the busy flag and, when cmd_valid is set, one SPI command
// header (opcode, three address bytes, data length and direction).
// APB port: register 0 (byte 0) expected chip id, register 1 (byte 4)
// real chip erase enable. Write only while the block is idle.
// The result is registered before it leaves on the result stream.
// Throughput: one item per cycle while s_tready is high; the decision logic
// sits between the input handshake and the result register, and the busy
// state updates on the same edge so a following item sees it immediately.
// When the receiver stalls, one more item is caught in a skid register;
// s_tready then drops until the result register drains.
// Reset (aresetn low, synchronous): no pending action, erase block counter
// cleared, both output stages empty, registers back to id 11 and emulated
// block-by-block chip erase.
module dataflash_command_sequencer_top #(
    parameter int PAGES     = 4096,
    parameter int PAGE_SIZE = 264
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] op
    input  logic [2:0]  s_tuser,
    // [7:0] status_byte, [21:8] page, [31:22] offset, [41:32] length,
    // [42] buffer_sel, [47:43] zero
    input  logic [47:0] s_tdata,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] cmd_valid, [8:1] opcode, [16:9] addr_hi, [24:17] addr_mid,
    // [32:25] addr_lo, [42:33] data_length, [44:43] data_dir,
    // [47:45] status, [48] busy_res, [55:49] zero
    output logic [55:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfcs_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    result_t res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    s_fire;
    logic    cfg_write;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_chip_id    <= 4'd11;
            cfg_reg.use_real_chip_erase <= 1'b0;
        end else if (cfg_write) begin
            // register index is the word address; byte lanes below it ignored
            unique case (paddr[2])
                REG_CHIP_ID:    cfg_reg.expected_chip_id    <= pwdata[3:0];
                REG_ERASE_MODE: cfg_reg.use_real_chip_erase <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CHIP_ID:    prdata = {28'b0, cfg_reg.expected_chip_id};
            REG_ERASE_MODE: prdata = {31'b0, cfg_reg.use_real_chip_erase};
            default:        prdata = '0;
        endcase
    end

    // ---------------- input unpack and decision ----------------
    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    assign item.op          = op_t'(s_tuser);
    assign item.status_byte = s_tdata[7:0];
    assign item.page        = s_tdata[21:8];
    assign item.offset      = s_tdata[31:22];
    assign item.length      = s_tdata[41:32];
    assign item.buffer_sel  = s_tdata[42];

    dfcs_core #(
        .PAGES     (PAGES),
        .PAGE_SIZE (PAGE_SIZE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (s_fire),
        .cfg     (cfg_reg),
        .item    (item),
        .res     (res)
    );

    // ---------------- result register with skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            // output stage free: drain skid first, else take the new result
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_fire;
            end
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (s_fire && out_valid_reg && !m_tready) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg};

    // ---------------- checks ----------------
    // the skid stage only fills behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output stage is empty");

    // a result without a command carries an empty header
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.cmd_valid) |->
        (out_reg.opcode == '0 && out_reg.data_dir == DIR_NONE &&
         out_reg.data_length == '0))
        else $error("header bits set without a command");

    // busy status means an action is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status == ST_BUSY) |-> out_reg.busy_res)
        else $error("busy status reported with no pending action");

    // the skid stage empties as soon as the receiver takes the held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid did not drain");

endmodule
